>>> hdl/tcjq_pkg.sv
package tcjq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W = 16;
	localparam int PAGE_W = 16;
	localparam int ENTRY_W = ID_W + PAGE_W;
	localparam int TOTAL_W = 32;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_SERVE = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic CLS_NORMAL = 1'b0;
	localparam logic CLS_PRIORITY = 1'b1;

endpackage

>>> hdl/tcjq_req_if.sv
interface tcjq_req_if;
	import tcjq_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [ID_W-1:0] job_id;
	logic [PAGE_W-1:0] page_count;
	logic priority_flag;

	modport source (output valid, opcode, job_id, page_count, priority_flag, input ready);
	modport sink (input valid, opcode, job_id, page_count, priority_flag, output ready);
endinterface

>>> hdl/tcjq_rsp_if.sv
interface tcjq_rsp_if;
	import tcjq_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] status;
	logic [ID_W-1:0] served_id;
	logic [PAGE_W-1:0] served_pages;
	logic from_priority;
	logic [CNT_W-1:0] normal_count;
	logic [CNT_W-1:0] priority_count;
	logic [TOTAL_W-1:0] normal_served_total;
	logic [TOTAL_W-1:0] priority_served_total;
	logic [TOTAL_W-1:0] pages_served_total;

	modport source (output valid, status, served_id, served_pages, from_priority, normal_count,
		priority_count, normal_served_total, priority_served_total, pages_served_total,
		input ready);
	modport sink (input valid, status, served_id, served_pages, from_priority, normal_count,
		priority_count, normal_served_total, priority_served_total, pages_served_total,
		output ready);
endinterface

>>> hdl/two_class_job_queue_with_cancel_unit.sv
// Two-class job queue with cancel. Requests: enqueue, serve, cancel; one response per request.
// Jobs live in two circular buffers in synchronous RAM, one per class. One request is in work at
// a time. Enqueue writes its entry, if there is room, as it is accepted and, like the unused
// opcode, goes straight to the output stage; serve first reads the head of its queue from
// RAM. A cancel scans entries, normal queue first and then priority, each a RAM read and a
// compare; on a hit it moves the later entries of that queue forward to close the gap, each a
// RAM read and a write-back. A finished response waits in an output register, and a new
// request is taken once the previous one has reached that register.
module two_class_job_queue_with_cancel_unit (
	input logic clk,
	input logic arst_n,
	tcjq_req_if.sink req,
	tcjq_rsp_if.source rsp
);
	import tcjq_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SERVE = 7'b0000010,
		S_SCAN_RD = 7'b0000100,
		S_SCAN_CK = 7'b0001000,
		S_SHIFT_RD = 7'b0010000,
		S_SHIFT_WR = 7'b0100000,
		S_FIN = 7'b1000000
	} state_t;

	state_t state_q;
	logic cls_q;
	logic [CNT_W-1:0] idx_q;
	logic [ADDR_W-1:0] head_q [2];
	logic [CNT_W-1:0] len_q [2];
	logic [ID_W-1:0] id_q;
	logic [1:0] status_q;
	logic [ID_W-1:0] rid_q;
	logic [PAGE_W-1:0] rpages_q;
	logic rprio_q;
	logic [TOTAL_W-1:0] normal_tot_q;
	logic [TOTAL_W-1:0] prio_tot_q;
	logic [TOTAL_W-1:0] pages_tot_q;
	logic out_valid_q;

	logic [1:0] wr_en;
	logic [1:0] rd_en;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] rdata [2];
	logic [ENTRY_W-1:0] cur_entry;
	logic [CNT_W-1:0] off;
	logic [CNT_W-1:0] idx_inc;
	logic enq_cls;
	logic serve_cls;
	logic [TOTAL_W:0] pages_sum;

	function automatic logic [ADDR_W-1:0] wrap_pos(logic [ADDR_W-1:0] base,
			logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	for (genvar g = 0; g < 2; g++) begin : g_ram
		tcjq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
			.clk(clk),
			.wr_en(wr_en[g]),
			.wr_addr(ram_waddr),
			.wr_data(ram_wdata),
			.rd_en(rd_en[g]),
			.rd_addr(ram_raddr),
			.rd_data(rdata[g])
		);
	end

	assign req.ready = (state_q == S_IDLE);
	assign cur_entry = rdata[cls_q];
	assign idx_inc = idx_q + CNT_W'(1);
	assign off = (state_q == S_SHIFT_RD) ? idx_inc : idx_q;
	assign enq_cls = req.priority_flag;
	assign serve_cls = (len_q[CLS_PRIORITY] != '0) ? CLS_PRIORITY : CLS_NORMAL;
	assign pages_sum = (TOTAL_W+1)'(pages_tot_q) + (TOTAL_W+1)'(cur_entry[PAGE_W-1:0]);

	always_comb begin
		wr_en = '0;
		rd_en = '0;
		ram_waddr = wrap_pos(head_q[cls_q], idx_q);
		ram_raddr = wrap_pos(head_q[cls_q], off);
		ram_wdata = cur_entry;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.opcode == OP_ENQUEUE && len_q[enq_cls] < DEPTH_CNT) begin
					wr_en[enq_cls] = 1'b1;
					ram_waddr = wrap_pos(head_q[enq_cls], len_q[enq_cls]);
					ram_wdata = {req.job_id, req.page_count};
				end else if (req.valid && req.opcode == OP_SERVE) begin
					rd_en[serve_cls] = (len_q[serve_cls] != '0);
					ram_raddr = head_q[serve_cls];
				end
			end
			S_SCAN_RD: rd_en[cls_q] = (idx_q < len_q[cls_q]);
			S_SHIFT_RD: rd_en[cls_q] = (idx_inc < len_q[cls_q]);
			S_SHIFT_WR: wr_en[cls_q] = 1'b1;
			S_SERVE, S_SCAN_CK, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cls_q <= CLS_NORMAL;
			idx_q <= '0;
			head_q[0] <= '0;
			head_q[1] <= '0;
			len_q[0] <= '0;
			len_q[1] <= '0;
			normal_tot_q <= '0;
			prio_tot_q <= '0;
			pages_tot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						rid_q <= '0;
						rpages_q <= '0;
						rprio_q <= 1'b0;
						id_q <= req.job_id;
						idx_q <= '0;
						case (req.opcode)
							OP_ENQUEUE: begin
								state_q <= S_FIN;
								if (len_q[enq_cls] < DEPTH_CNT) begin
									len_q[enq_cls] <= len_q[enq_cls] + CNT_W'(1);
									status_q <= ST_OK;
								end else begin
									status_q <= ST_FULL;
								end
							end
							OP_SERVE: begin
								cls_q <= serve_cls;
								if (len_q[serve_cls] != '0) begin
									status_q <= ST_OK;
									state_q <= S_SERVE;
								end else begin
									status_q <= ST_EMPTY;
									state_q <= S_FIN;
								end
							end
							OP_CANCEL: begin
								cls_q <= CLS_NORMAL;
								status_q <= ST_OK;
								state_q <= S_SCAN_RD;
							end
							default: begin
								status_q <= ST_OK;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SERVE: begin
					rid_q <= cur_entry[ENTRY_W-1:PAGE_W];
					rpages_q <= cur_entry[PAGE_W-1:0];
					rprio_q <= cls_q;
					head_q[cls_q] <= wrap_pos(head_q[cls_q], CNT_W'(1));
					len_q[cls_q] <= len_q[cls_q] - CNT_W'(1);
					if (cls_q == CLS_PRIORITY) begin
						if (prio_tot_q != '1) prio_tot_q <= prio_tot_q + TOTAL_W'(1);
					end else begin
						if (normal_tot_q != '1) normal_tot_q <= normal_tot_q + TOTAL_W'(1);
					end
					pages_tot_q <= pages_sum[TOTAL_W] ? '1 : pages_sum[TOTAL_W-1:0];
					state_q <= S_FIN;
				end
				S_SCAN_RD: begin
					if (idx_q < len_q[cls_q]) begin
						state_q <= S_SCAN_CK;
					end else if (cls_q == CLS_NORMAL) begin
						cls_q <= CLS_PRIORITY;
						idx_q <= '0;
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q <= S_FIN;
					end
				end
				S_SCAN_CK: begin
					if (cur_entry[ENTRY_W-1:PAGE_W] == id_q) begin
						rid_q <= cur_entry[ENTRY_W-1:PAGE_W];
						rpages_q <= cur_entry[PAGE_W-1:0];
						rprio_q <= cls_q;
						state_q <= S_SHIFT_RD;
					end else begin
						idx_q <= idx_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					if (idx_inc < len_q[cls_q]) begin
						state_q <= S_SHIFT_WR;
					end else begin
						len_q[cls_q] <= len_q[cls_q] - CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_SHIFT_WR: begin
					idx_q <= idx_inc;
					state_q <= S_SHIFT_RD;
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						rsp.status <= status_q;
						rsp.served_id <= rid_q;
						rsp.served_pages <= rpages_q;
						rsp.from_priority <= rprio_q;
						rsp.normal_count <= len_q[CLS_NORMAL];
						rsp.priority_count <= len_q[CLS_PRIORITY];
						rsp.normal_served_total <= normal_tot_q;
						rsp.priority_served_total <= prio_tot_q;
						rsp.pages_served_total <= pages_tot_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q[0] <= DEPTH_CNT && len_q[1] <= DEPTH_CNT)
		else $error("queue length beyond depth");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("request accepted without leaving idle");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT_WR |-> idx_inc < len_q[cls_q])
		else $error("gap close beyond queue length");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.served_id))
		else $error("pending response overwritten");
`endif
endmodule

>>> hdl/tcjq_ram.sv
module tcjq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
